// ===== hdl/aesc_pkg.sv =====
// Package with the AES tables, byte-level helper functions and control types.
`default_nettype none
package aesc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LENGTH = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DIRECTION = 3'd5;

  localparam logic [1:0] KEY_LEN_128 = 2'd0;
  localparam logic [1:0] KEY_LEN_192 = 2'd1;

  localparam logic [2047:0] SBOX_V = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [2047:0] INV_SBOX_V = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  typedef struct packed {
    logic blk_load;
    logic exp_init;
    logic exp_step;
    logic pre;
    logic add0;
    logic rnd_step;
    logic out_load;
  } aesc_cmd_t;

  typedef struct packed {
    logic exp_last;
    logic rnd_last;
  } aesc_sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] b, input logic inv);
    logic [10:0] pos;
    pos = {~b, 3'b000};
    return inv ? INV_SBOX_V[pos +: 8] : SBOX_V[pos +: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24], 1'b0), sbox(w[23:16], 1'b0), sbox(w[15:8], 1'b0),
            sbox(w[7:0], 1'b0)};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] m3 [4];
    for (int i = 0; i < 4; i++) begin
      a[i] = c[31-8*i -: 8];
      x2[i] = xt(a[i]);
      x4[i] = xt(x2[i]);
      x8[i] = xt(x4[i]);
      m3[i] = x2[i] ^ a[i];
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    if (!inv) begin
      return {x2[0] ^ m3[1] ^ a[2] ^ a[3], a[0] ^ x2[1] ^ m3[2] ^ a[3],
              a[0] ^ a[1] ^ x2[2] ^ m3[3], m3[0] ^ a[1] ^ a[2] ^ x2[3]};
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3], m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3], mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
    end
    return t;
  endfunction

  function automatic logic [127:0] shift_sub(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (!inv) begin
          t[127-8*(c*4+r) -: 8] = sbox(s[127-8*(((c+r)%4)*4+r) -: 8], 1'b0);
        end else begin
          t[127-8*(((c+r)%4)*4+r) -: 8] = sbox(s[127-8*(c*4+r) -: 8], 1'b1);
        end
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aesc_if.sv =====
// Valid/ready channel interfaces for input blocks and result blocks.
`default_nettype none
interface aesc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, output block_high, output block_low, input ready);
  modport sink (input valid, input block_high, input block_low, output ready);
endinterface

interface aesc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, output result_high, output result_low, input ready);
  modport sink (input valid, input result_high, input result_low, output ready);
endinterface
`default_nettype wire

// ===== hdl/aesc_datapath.sv =====
// Datapath with key registers, key expansion, round-key memory and the round unit.
`default_nettype none
module aesc_datapath import aesc_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = 14
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire aesc_cmd_t           cmd_i,
  output aesc_sts_t                sts_o,
  input  wire logic [63:0]         blk_high_i,
  input  wire logic [63:0]         blk_low_i,
  output logic [63:0]              res_high_o,
  output logic [63:0]              res_low_o
);

  localparam int unsigned RW = $clog2(MAX_ROUNDS + 1);
  localparam int unsigned CW = RW + 2;
  localparam logic [RW-1:0] NK_LIM = RW'(((MAX_ROUNDS - 6) / 2) * 2);

  logic [63:0] key_q [4];
  logic [1:0]  klen_q;
  logic        dir_q;

  logic [RW-1:0] nk_sel, nk, nr;

  logic [CW-1:0]  cnt_q, cnt_d;
  logic [2:0]     phase_q, phase_d;
  logic [7:0]     rcon_q, rcon_d;
  logic [31:0]    win_q [8];
  logic [95:0]    asm_q;
  logic [127:0]   rk_full_q;
  logic [RW-1:0]  rk_addr_q;
  logic           rk_imc_q;
  logic           rk_wr_q, rk_wr_d;
  logic [31:0]    tmp, wold, word, kword;
  logic [RW-1:0]  qidx;

  logic [127:0]  rk_mem [MAX_ROUNDS+1];
  logic [127:0]  rk_rd_q;
  logic [127:0]  st_q;
  logic [127:0]  res_q;
  logic [127:0]  rnd_val;
  logic [RW-1:0] rnd_q, rnd_d;
  logic          rd_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      klen_q <= KEY_LEN_128;
      dir_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_WORD_0: key_q[0] <= cfg_wdata_i;
        CFG_KEY_WORD_1: key_q[1] <= cfg_wdata_i;
        CFG_KEY_WORD_2: key_q[2] <= cfg_wdata_i;
        CFG_KEY_WORD_3: key_q[3] <= cfg_wdata_i;
        CFG_KEY_LENGTH: klen_q <= cfg_wdata_i[1:0];
        CFG_DIRECTION:  dir_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (klen_q)
      KEY_LEN_128: nk_sel = RW'(4);
      KEY_LEN_192: nk_sel = RW'(6);
      default:     nk_sel = RW'(8);
    endcase
    nk = (nk_sel > NK_LIM) ? NK_LIM : nk_sel;
    nr = nk + RW'(6);
  end

  always_comb begin
    tmp = win_q[7];
    if (phase_q == 3'd0) begin
      tmp = sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon_q, 24'h0};
    end else if (nk == RW'(8) && phase_q == 3'd4) begin
      tmp = sub_word(win_q[7]);
    end
    if (nk == RW'(4)) begin
      wold = win_q[4];
    end else if (nk == RW'(6)) begin
      wold = win_q[2];
    end else begin
      wold = win_q[0];
    end
    kword = cnt_q[0] ? key_q[cnt_q[2:1]][31:0] : key_q[cnt_q[2:1]][63:32];
    word = (cnt_q < CW'(nk)) ? kword : (wold ^ tmp);
    qidx = cnt_q[CW-1:2];

    cnt_d   = cnt_q;
    phase_d = phase_q;
    rcon_d  = rcon_q;
    rk_wr_d = 1'b0;
    if (cmd_i.exp_init) begin
      cnt_d   = '0;
      phase_d = '0;
      rcon_d  = 8'h01;
    end else if (cmd_i.exp_step) begin
      cnt_d   = cnt_q + CW'(1);
      phase_d = (phase_q == 3'(nk - RW'(1))) ? 3'd0 : phase_q + 3'd1;
      if (cnt_q >= CW'(nk) && phase_q == 3'd0) rcon_d = xt(rcon_q);
      rk_wr_d = (cnt_q[1:0] == 2'b11);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= '0;
      rcon_q  <= 8'h01;
      rk_wr_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      rcon_q  <= rcon_d;
      rk_wr_q <= rk_wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_step) begin
      for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
      win_q[7] <= word;
      asm_q <= {asm_q[63:0], word};
      if (cnt_q[1:0] == 2'b11) begin
        rk_full_q <= {asm_q, word};
        rk_addr_q <= dir_q ? (nr - qidx) : qidx;
        rk_imc_q  <= dir_q && (qidx != '0) && (qidx != nr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rk_wr_q) begin
      rk_mem[rk_addr_q] <= rk_imc_q ? mix_all(rk_full_q, 1'b1) : rk_full_q;
    end
    if (rd_en) begin
      rk_rd_q <= rk_mem[rnd_d];
    end
  end

  always_comb begin
    rnd_d = rnd_q;
    if (cmd_i.pre) begin
      rnd_d = '0;
    end else if (cmd_i.add0 || cmd_i.rnd_step) begin
      rnd_d = rnd_q + RW'(1);
    end
    rd_en = cmd_i.pre || cmd_i.add0 || (cmd_i.rnd_step && (rnd_q != nr));
    rnd_val = shift_sub(st_q, dir_q);
    if (rnd_q != nr) rnd_val = mix_all(rnd_val, dir_q);
    rnd_val = rnd_val ^ rk_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else begin
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_load) begin
      st_q <= {blk_high_i, blk_low_i};
    end else if (cmd_i.add0) begin
      st_q <= st_q ^ rk_rd_q;
    end else if (cmd_i.rnd_step) begin
      st_q <= rnd_val;
    end
    if (cmd_i.out_load) begin
      res_q <= st_q;
    end
  end

  assign sts_o.exp_last = (cnt_q == {nr, 2'b11});
  assign sts_o.rnd_last = (rnd_q == nr);
  assign res_high_o = res_q[127:64];
  assign res_low_o  = res_q[63:0];

endmodule
`default_nettype wire

// ===== hdl/aesc_ctrl.sv =====
// Controller state machine that sequences key expansion, rounds and result hand-off.
`default_nettype none
module aesc_ctrl import aesc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output aesc_cmd_t               cmd_o,
  input  wire aesc_sts_t          sts_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXPAND = 3'd1;
  localparam logic [2:0] ST_FLUSH  = 3'd2;
  localparam logic [2:0] ST_PRE    = 3'd3;
  localparam logic [2:0] ST_ADD0   = 3'd4;
  localparam logic [2:0] ST_ROUND  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       sched_q, sched_d;
  logic       ovld_q, ovld_d;
  logic       accept;

  assign accept = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    sched_d = sched_q;
    ovld_d  = ovld_q && !out_ready_i;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.blk_load = 1'b1;
          if (sched_q) begin
            state_d = ST_PRE;
          end else begin
            cmd_o.exp_init = 1'b1;
            state_d = ST_EXPAND;
          end
        end
      end
      ST_EXPAND: begin
        cmd_o.exp_step = 1'b1;
        if (sts_i.exp_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        sched_d = 1'b1;
        state_d = ST_PRE;
      end
      ST_PRE: begin
        cmd_o.pre = 1'b1;
        state_d = ST_ADD0;
      end
      ST_ADD0: begin
        cmd_o.add0 = 1'b1;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.rnd_step = 1'b1;
        if (sts_i.rnd_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovld_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i && cfg_idx_i <= CFG_DIRECTION) sched_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sched_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sched_q <= sched_d;
      ovld_q  <= ovld_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ovld_q;

  a_build_when_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !sched_q |=> state_q == ST_EXPAND)
    else $error("Schedule was not rebuilt for a stale key.");

  a_flush_marks_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |=> sched_q && state_q == ST_PRE)
    else $error("Expansion did not complete into the round sequence.");

  a_rounds_follow_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADD0 |=> state_q == ST_ROUND)
    else $error("Initial key addition not followed by rounds.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !ovld_q || out_ready_i)
    else $error("Result register overwritten before it was taken.");

endmodule
`default_nettype wire

// ===== hdl/aes_block_cipher_engine_core.sv =====
// Top level of the AES-128/192/256 block cipher engine.
//
//   Channel   Direction  Payload                      Accepted when
//   blk_i     in         block_high, block_low        valid && ready
//   res_o     out        result_high, result_low      valid && ready
//   cfg       in         cfg_idx_i, cfg_wdata_i       cfg_we_i
//
// A block passes through the first round-key read, the initial key addition and Nr rounds, where
// Nr is 10, 12 or 14; the single shared round unit does one round per cycle, and a new block is
// taken only once the previous block's result has been loaded into the output register.
// The first block after reset or after a write to a key word, the key length or the direction
// first expands the key into the round-key memory, one word per cycle.
// The input is ready only while the engine is idle. A finished result waits in the output
// register, and the next transaction is taken meanwhile; the engine stalls before its
// result is loaded when that register is still full.
`default_nettype none
module aes_block_cipher_engine_core import aesc_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = 14
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  aesc_in_if.sink                  blk_i,
  aesc_out_if.source               res_o
);

  aesc_cmd_t cmd;
  aesc_sts_t sts;

  aesc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .in_valid_i  (blk_i.valid),
    .in_ready_o  (blk_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  aesc_datapath #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .blk_high_i  (blk_i.block_high),
    .blk_low_i   (blk_i.block_low),
    .res_high_o  (res_o.result_high),
    .res_low_o   (res_o.result_low)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the AES block cipher engine core with a built-in cipher predictor.
`default_nettype none
module testbench;
  import aesc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_7 = 3'd7;
  localparam logic [1:0] KEY_LEN_256 = 2'd2;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned SettleCycles = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  aesc_in_if blk_if ();
  aesc_out_if res_if ();

  aes_block_cipher_engine_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .blk_i      (blk_if.sink),
    .res_o      (res_if.source)
  );

  initial begin
    blk_if.valid = 1'b0;
    blk_if.block_high = '0;
    blk_if.block_low = '0;
    res_if.ready = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  logic [63:0] key_words [4];
  logic [1:0] key_len_sel;
  logic decrypt_mode;
  logic [127:0] result_block_q [$];
  logic [7:0] fwd_sbox [256];
  logic [7:0] rev_sbox [256];
  int unsigned error_count = 0;
  int unsigned hold_cycles = 0;
  bit steady_flow = 1'b0;
  int unsigned quiet_cycles = 0;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic void build_sbox_tables();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int e = 0; e < 254; e++) inv = gmul(inv, x[7:0]);
      s = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
      fwd_sbox[x] = s;
      rev_sbox[s] = x[7:0];
    end
  endfunction

  function automatic void mix_columns(ref logic [7:0] s [16], input logic inv);
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      if (!inv) begin
        s[4*c]   = gmul(a0, 8'd2) ^ gmul(a1, 8'd3) ^ a2 ^ a3;
        s[4*c+1] = a0 ^ gmul(a1, 8'd2) ^ gmul(a2, 8'd3) ^ a3;
        s[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'd2) ^ gmul(a3, 8'd3);
        s[4*c+3] = gmul(a0, 8'd3) ^ a1 ^ a2 ^ gmul(a3, 8'd2);
      end else begin
        s[4*c]   = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
        s[4*c+1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
        s[4*c+2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
        s[4*c+3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
      end
    end
  endfunction

  function automatic logic [127:0] aes_transform(input logic [127:0] blk);
    logic [31:0] w [60];
    logic [127:0] rk [15];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] k [16];
    logic [31:0] tw;
    logic [7:0] rcon;
    int nk, nr;
    logic [127:0] out;
    nk = (key_len_sel >= KEY_LEN_256) ? 8 : 4 + 2 * key_len_sel;
    nr = nk + 6;
    rcon = 8'h01;
    for (int i = 0; i < nk; i++) begin
      w[i] = i[0] ? key_words[(i >> 1) & 3][31:0] : key_words[(i >> 1) & 3][63:32];
    end
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      tw = w[i-1];
      if (i % nk == 0) begin
        tw = {tw[23:0], tw[31:24]};
        tw = {fwd_sbox[tw[31:24]], fwd_sbox[tw[23:16]], fwd_sbox[tw[15:8]], fwd_sbox[tw[7:0]]};
        tw ^= {rcon, 24'h0};
        rcon = gmul(rcon, 8'd2);
      end else if (nk > 6 && i % nk == 4) begin
        tw = {fwd_sbox[tw[31:24]], fwd_sbox[tw[23:16]], fwd_sbox[tw[15:8]], fwd_sbox[tw[7:0]]};
      end
      w[i] = w[i-nk] ^ tw;
    end
    for (int r = 0; r <= nr; r++) begin
      if (!decrypt_mode) begin
        rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
      end else begin
        rk[r] = {w[4*(nr-r)], w[4*(nr-r)+1], w[4*(nr-r)+2], w[4*(nr-r)+3]};
        if (r != 0 && r != nr) begin
          for (int i = 0; i < 16; i++) k[i] = rk[r][127-8*i -: 8];
          mix_columns(k, 1'b1);
          for (int i = 0; i < 16; i++) rk[r][127-8*i -: 8] = k[i];
        end
      end
    end
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rk[0][127-8*i -: 8];
    for (int r = 1; r <= nr; r++) begin
      for (int c = 0; c < 4; c++) begin
        for (int q = 0; q < 4; q++) begin
          if (!decrypt_mode) t[c*4+q] = fwd_sbox[s[((c+q)&3)*4+q]];
          else t[((c+q)&3)*4+q] = rev_sbox[s[c*4+q]];
        end
      end
      s = t;
      if (r != nr) mix_columns(s, decrypt_mode);
      for (int i = 0; i < 16; i++) s[i] ^= rk[r][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) out[127-8*i -: 8] = s[i];
    return out;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3: begin
        key_words[idx[1:0]] = data;
      end
      CFG_KEY_LENGTH: key_len_sel = data[1:0];
      CFG_DIRECTION: decrypt_mode = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1, input logic [63:0] k2,
                          input logic [63:0] k3, input logic [1:0] len, input logic dir);
    write_reg(CFG_KEY_WORD_0, k0);
    write_reg(CFG_KEY_WORD_1, k1);
    write_reg(CFG_KEY_WORD_2, k2);
    write_reg(CFG_KEY_WORD_3, k3);
    write_reg(CFG_KEY_LENGTH, {62'd0, len});
    write_reg(CFG_DIRECTION, {63'd0, dir});
  endtask

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    if (!steady_flow) begin
      while ($urandom_range(99) < 33) begin
        blk_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    blk_if.valid <= 1'b1;
    blk_if.block_high <= hi;
    blk_if.block_low <= lo;
    do @(posedge clk_i); while (!blk_if.ready);
    result_block_q.push_back(aes_transform({hi, lo}));
  endtask

  task automatic drain_results();
    blk_if.valid <= 1'b0;
    while (result_block_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (result_block_q.size() == 0) begin
          $error("unexpected result transaction %h_%h", res_if.result_high, res_if.result_low);
          error_count++;
        end else begin
          logic [127:0] exp_blk;
          exp_blk = result_block_q.pop_front();
          if (res_if.result_high !== exp_blk[127:64]) begin
            $error("result_high expected %h actual %h", exp_blk[127:64], res_if.result_high);
            error_count++;
          end
          if (res_if.result_low !== exp_blk[63:0]) begin
            $error("result_low expected %h actual %h", exp_blk[63:0], res_if.result_low);
            error_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 33);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((blk_if.valid && blk_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed_vectors();
    logic [63:0] patt [3];
    patt[0] = 64'h0;
    patt[1] = '1;
    patt[2] = 64'haaaa_aaaa_aaaa_aaaa;
    for (int len = 0; len < 4; len++) begin
      for (int dir = 0; dir < 2; dir++) begin
        if (len[0]) load_key('1, '1, '1, '1, len[1:0], dir[0]);
        else load_key(rand64(), rand64(), rand64(), rand64(), len[1:0], dir[0]);
        for (int p = 0; p < 3; p++) send_block(patt[p], patt[(p + len) % 3]);
        drain_results();
      end
    end
  endtask

  task automatic test_reset_key();
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    drain_results();
  endtask

  task automatic test_rewrite_and_spare_regs();
    write_reg(CFG_SPARE_6, rand64());
    write_reg(CFG_SPARE_7, rand64());
    write_reg(CFG_DIRECTION, {63'd0, decrypt_mode});
    send_block(rand64(), rand64());
    drain_results();
    write_reg(CFG_SPARE_7, '1);
    write_reg(CFG_KEY_LENGTH, {62'd0, key_len_sel});
    send_block(rand64(), rand64());
    drain_results();
  endtask

  task automatic test_backpressure();
    load_key(rand64(), rand64(), rand64(), rand64(), KEY_LEN_256, 1'b0);
    hold_cycles = 400;
    steady_flow = 1'b1;
    for (int i = 0; i < 40; i++) send_block(rand64(), rand64());
    steady_flow = 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 14; ph++) begin
      load_key(rand64(), rand64(), rand64(), rand64(), 2'($urandom_range(3)),
               1'($urandom_range(1)));
      steady_flow = (ph == 5);
      for (int i = 0; i < 100; i++) send_block(rand64(), rand64());
      steady_flow = 1'b0;
      drain_results();
    end
  endtask

  initial begin
    build_sbox_tables();
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    key_len_sel = KEY_LEN_128;
    decrypt_mode = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_key();
    test_directed_vectors();
    test_rewrite_and_spare_regs();
    test_backpressure();
    test_random_traffic();
    if (error_count == 0 && result_block_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
